[rtl/core/ptc_pkg.sv]
// Package for the pre/post trigger capture block: payload structs, the
// command word passed from front to back end, and shared helpers. No dependencies.
package ptc_pkg;

   localparam int PreDepth   = 64;
   localparam int RecordBits = 32;
   localparam int AddrBits   = (PreDepth > 1) ? $clog2(PreDepth) : 1;
   localparam int FillBits   = $clog2(PreDepth + 1);
   localparam int QueueDepth = 4;

   localparam logic [31:0] RecMask = 32'((64'd1 << RecordBits) - 64'd1);

   localparam logic [1:0] PhaseDirect = 2'd0;
   localparam logic [1:0] PhaseDump   = 2'd1;
   localparam logic [1:0] PhasePost   = 2'd2;

   localparam logic [1:0] CsrEventMode   = 2'd0;
   localparam logic [1:0] CsrStampEnable = 2'd1;
   localparam logic [1:0] CsrPreCount    = 2'd2;
   localparam logic [1:0] CsrPostLimit   = 2'd3;

   typedef struct packed {
      logic [31:0] record;
      logic        store;
      logic        batch_last;
   } req_data_type;

   typedef struct packed {
      logic [31:0] out_record;
      logic [47:0] stamp;
      logic [1:0]  phase;
      logic        last;
   } rsp_data_type;

   typedef struct packed {
      logic        event_mode;
      logic        stamp_enable;
      logic [6:0]  pre_count;
      logic [19:0] post_count_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      CmdNone,
      CmdSingle,
      CmdDump
   } cmd_kind_type;

   // One word of work for the back end: an optional ring write followed by
   // either nothing, one result, or a dump of the ring.
   typedef struct packed {
      logic                wr_en;
      logic [AddrBits-1:0] wr_addr;
      logic [31:0]         data;
      cmd_kind_type        kind;
      logic [47:0]         stamp;
      logic [1:0]          phase;
      logic                stamp_step;
      logic [AddrBits-1:0] dump_head;
      logic [FillBits-1:0] dump_count;
   } cmd_type;

   // Ring address plus an offset of at most PreDepth, wrapped into the ring.
   function automatic logic [AddrBits-1:0] ring_add(input logic [AddrBits-1:0] a,
                                                    input logic [FillBits-1:0] b);
      logic [FillBits:0] sum;
      sum = (FillBits + 1)'(a) + (FillBits + 1)'(b);
      if (sum >= (FillBits + 1)'(PreDepth)) begin
         sum = sum - (FillBits + 1)'(PreDepth);
      end
      return AddrBits'(sum);
   endfunction

endpackage

[rtl/core/ptc_front.sv]
// Front end of the capture block: accepts sample words, keeps the sample index,
// ring pointers and post-trigger state, and issues command words. Uses ptc_pkg.
module ptc_front
   import ptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         cmd_push,
   output cmd_type      cmd_data,
   input  logic         cmd_full
);

   logic [47:0]         sample_index_ff, sample_index_in;
   logic [AddrBits-1:0] ring_head_ff, ring_head_in;
   logic [FillBits-1:0] ring_fill_ff, ring_fill_in;
   logic                post_active_ff, post_active_in;
   logic [19:0]         post_cnt_ff, post_cnt_in;
   logic                accept;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;

   always_comb begin
      logic [47:0]         now;
      logic [47:0]         gated;
      logic [31:0]         rec;
      logic                act;
      logic [19:0]         cnt;
      logic [19:0]         cnt_next;
      logic [FillBits-1:0] cap;
      logic [FillBits-1:0] fill;
      logic [AddrBits-1:0] head;

      now      = sample_index_ff;
      gated    = cfg.stamp_enable ? now : 48'd0;
      rec      = req_data.record & RecMask;
      act      = post_active_ff;
      cnt      = post_cnt_ff;
      cnt_next = '0;
      fill     = ring_fill_ff;
      head     = ring_head_ff;
      if (32'(cfg.pre_count) > PreDepth) begin
         cap = FillBits'(PreDepth);
      end else begin
         cap = FillBits'(cfg.pre_count);
      end

      cmd_data            = '0;
      cmd_data.kind       = CmdNone;
      cmd_data.data       = rec;
      cmd_data.stamp      = gated;
      cmd_data.stamp_step = cfg.stamp_enable;

      if (!cfg.event_mode) begin
         if (req_data.store) begin
            cmd_data.kind  = CmdSingle;
            cmd_data.phase = PhaseDirect;
         end
      end else begin
         if (act && req_data.store) begin
            cnt = '0;
         end
         if (act && cnt >= cfg.post_count_limit) begin
            act = 1'b0;
            cnt = '0;
         end
         if (act) begin
            cmd_data.kind  = CmdSingle;
            cmd_data.phase = PhasePost;
            cnt_next       = cnt + 20'd1;
            if (cnt_next == 20'd0 || cnt_next >= cfg.post_count_limit) begin
               act = 1'b0;
               cnt = '0;
            end else begin
               cnt = cnt_next;
            end
         end else begin
            if (cap == '0) begin
               fill = '0;
            end else begin
               // Drop the oldest entries until the new word fits.
               if (fill >= cap) begin
                  head = ring_add(head, fill - cap + FillBits'(1));
                  fill = cap - FillBits'(1);
               end
               cmd_data.wr_en   = 1'b1;
               cmd_data.wr_addr = ring_add(head, fill);
               fill             = fill + FillBits'(1);
            end
            if (req_data.store && req_data.batch_last) begin
               if (fill != '0) begin
                  cmd_data.kind       = CmdDump;
                  cmd_data.phase      = PhaseDump;
                  cmd_data.dump_head  = head;
                  cmd_data.dump_count = fill;
                  cmd_data.stamp      = cfg.stamp_enable ?
                                        (now - 48'(fill) + 48'd1) : 48'd0;
               end
               head = ring_add(head, fill);
               fill = '0;
               cnt  = '0;
               act  = (cfg.post_count_limit != 20'd0);
            end
         end
      end

      cmd_push        = accept && (cmd_data.wr_en || cmd_data.kind != CmdNone);
      sample_index_in = sample_index_ff;
      ring_head_in    = ring_head_ff;
      ring_fill_in    = ring_fill_ff;
      post_active_in  = post_active_ff;
      post_cnt_in     = post_cnt_ff;
      if (accept) begin
         sample_index_in = now + 48'd1;
         ring_head_in    = head;
         ring_fill_in    = fill;
         post_active_in  = act;
         post_cnt_in     = cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         ring_head_ff    <= '0;
         ring_fill_ff    <= '0;
         post_active_ff  <= 1'b0;
         post_cnt_ff     <= '0;
      end else begin
         sample_index_ff <= sample_index_in;
         ring_head_ff    <= ring_head_in;
         ring_fill_ff    <= ring_fill_in;
         post_active_ff  <= post_active_in;
         post_cnt_ff     <= post_cnt_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(ring_fill_ff) <= PreDepth)
      else $error("ring fill exceeds ring depth");

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !post_active_ff |-> post_cnt_ff == 20'd0)
      else $error("post counter nonzero outside post phase");

endmodule

[rtl/core/ptc_queue.sv]
// Short command queue between the front and back ends of the capture block.
// Uses cmd_type from ptc_pkg.
module ptc_queue
   import ptc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntBits = $clog2(QueueDepth + 1);

   cmd_type             slots_ff [QueueDepth];
   logic [PtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]  count_ff, count_in;

   assign full     = (count_ff == CntBits'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QueueDepth - 1) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QueueDepth - 1) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("command queue written while full");

endmodule

[rtl/core/ptc_back.sv]
// Back end of the capture block: holds the pre-trigger ring memory, carries out
// command words and drives the registered result channel. Uses ptc_pkg.
module ptc_back
   import ptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd_data,
   input  logic         cmd_empty,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   typedef enum logic [1:0] {
      StIdle,
      StRead,
      StShow
   } state_type;

   logic [31:0]         ring_mem [PreDepth];
   logic [31:0]         rd_data_ff;

   state_type           state_ff, state_in;
   logic [AddrBits-1:0] rd_addr_ff, rd_addr_in;
   logic [FillBits-1:0] remain_ff, remain_in;
   logic [47:0]         stamp_ff, stamp_in;
   logic                step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_data_type        rsp_data_ff, rsp_data_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cmd_pop   = (state_ff == StIdle) && !cmd_empty &&
                      (cmd_data.kind == CmdNone || out_free);

   always_comb begin
      state_in     = state_ff;
      rd_addr_in   = rd_addr_ff;
      remain_in    = remain_ff;
      stamp_in     = stamp_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         StIdle: begin
            if (cmd_pop) begin
               unique case (cmd_data.kind)
                  CmdSingle: begin
                     rsp_valid_in           = 1'b1;
                     rsp_data_in.out_record = cmd_data.data;
                     rsp_data_in.stamp      = cmd_data.stamp;
                     rsp_data_in.phase      = cmd_data.phase;
                     rsp_data_in.last       = 1'b1;
                  end
                  CmdDump: begin
                     state_in   = StRead;
                     rd_addr_in = cmd_data.dump_head;
                     remain_in  = cmd_data.dump_count;
                     stamp_in   = cmd_data.stamp;
                     step_in    = cmd_data.stamp_step;
                  end
                  default: begin
                  end
               endcase
            end
         end
         StRead: begin
            state_in = StShow;
         end
         StShow: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_record = rd_data_ff;
               rsp_data_in.stamp      = stamp_ff;
               rsp_data_in.phase      = PhaseDump;
               rsp_data_in.last       = (remain_ff == FillBits'(1));
               stamp_in               = stamp_ff + 48'(step_ff);
               rd_addr_in             = ring_add(rd_addr_ff, FillBits'(1));
               remain_in              = remain_ff - FillBits'(1);
               state_in               = (remain_ff == FillBits'(1)) ? StIdle : StRead;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rd_addr_ff   <= '0;
         remain_ff    <= '0;
         stamp_ff     <= '0;
         step_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rd_addr_ff   <= rd_addr_in;
         remain_ff    <= remain_in;
         stamp_ff     <= stamp_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // Ring memory: one write port fed by commands, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_data.wr_en) begin
         ring_mem[cmd_data.wr_addr] <= cmd_data.data;
      end
      if (state_ff == StRead) begin
         rd_data_ff <= ring_mem[rd_addr_ff];
      end
   end

   a_dump_count: assert property (@(posedge clock) disable iff (reset)
      state_ff != StIdle |-> remain_ff != '0)
      else $error("ring dump running with nothing left to send");

endmodule

[rtl/core/pre_post_trigger_capture_top.sv]
// With the back end idle, a single result word passes through the command queue and the output
// register on its way to rsp_data; a ring dump adds a ring memory read before its first word.
// Throughput: one sample word per cycle while only single results are produced and rsp_stall
// stays low; a dump holds the back end in its read and show states (one
// memory read and one output load per entry) while the four-entry queue lets the front run on.
// Reset is synchronous, active high, and clears all control state but not the ring memory.
module pre_post_trigger_capture_top
   import ptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_push;
   logic    cmd_pop;
   logic    cmd_full;
   logic    cmd_empty;
   cmd_type cmd_push_data;
   cmd_type cmd_pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrEventMode:   cfg_in.event_mode       = csr_wdata[0];
            CsrStampEnable: cfg_in.stamp_enable     = csr_wdata[0];
            CsrPreCount:    cfg_in.pre_count        = csr_wdata[6:0];
            CsrPostLimit:   cfg_in.post_count_limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_push_data),
      .cmd_full  (cmd_full)
   );

   ptc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .empty     (cmd_empty)
   );

   ptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_pop_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/capture_check_pkg.sv]
// Scoreboard for the pre/post trigger capture block: a cycle-free predictor of
// the capture behaviour and a queue of the result words it expects.
// Depends on ptc_pkg for the payload structs, phase codes and register indexes.
package capture_check_pkg;
   import ptc_pkg::*;

   localparam int unsigned ReportLimit = 50;

   class capture_scoreboard;
      rsp_data_type expected_q[$];
      logic [31:0]  ring[PreDepth];
      int unsigned  ring_head;
      int unsigned  ring_fill;
      bit           post_active;
      logic [19:0]  post_counter;
      logic [47:0]  sample_index;
      cfg_type      cfg;
      int unsigned  errors;
      int unsigned  words_in;
      int unsigned  words_out;
      int unsigned  dump_words;
      int unsigned  post_words;

      function new();
         ring_head    = 0;
         ring_fill    = 0;
         post_active  = 1'b0;
         post_counter = '0;
         sample_index = '0;
         cfg          = '0;
         errors       = 0;
         words_in     = 0;
         words_out    = 0;
         dump_words   = 0;
         post_words   = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [19:0] value);
         case (idx)
            CsrEventMode:   cfg.event_mode       = value[0];
            CsrStampEnable: cfg.stamp_enable     = value[0];
            CsrPreCount:    cfg.pre_count        = value[6:0];
            CsrPostLimit:   cfg.post_count_limit = value;
            default: ;
         endcase
      endfunction

      function void add_result(input logic [31:0] rec, input logic [47:0] stamp,
                               input logic [1:0] phase);
         rsp_data_type r;
         r.out_record = rec;
         r.stamp      = cfg.stamp_enable ? stamp : 48'd0;
         r.phase      = phase;
         r.last       = 1'b0;
         expected_q.push_back(r);
      endfunction

      // Capacities above the ring depth behave as the ring depth; a lowered
      // capacity drops the oldest entries until the new record fits.
      function void ring_insert(input logic [31:0] rec);
         int unsigned cap;
         cap = (cfg.pre_count > PreDepth) ? PreDepth : cfg.pre_count;
         if (cap == 0) begin
            ring_fill = 0;
            return;
         end
         while (ring_fill >= cap) begin
            ring_head = (ring_head + 1) % PreDepth;
            ring_fill--;
         end
         ring[(ring_head + ring_fill) % PreDepth] = rec;
         ring_fill++;
      endfunction

      function void note_input(input req_data_type w);
         logic [47:0]  now;
         logic [31:0]  rec;
         int unsigned  before_n;
         int unsigned  k;
         rsp_data_type r;
         now          = sample_index;
         rec          = w.record & RecMask;
         sample_index = now + 48'd1;
         before_n     = expected_q.size();
         words_in++;
         if (!cfg.event_mode) begin
            if (w.store) add_result(rec, now, PhaseDirect);
         end else begin
            if (post_active && w.store) post_counter = '0;
            // A limit lowered under the running count ends the post phase at once.
            if (post_active && post_counter >= cfg.post_count_limit) begin
               post_active  = 1'b0;
               post_counter = '0;
            end
            if (post_active) begin
               add_result(rec, now, PhasePost);
               post_words++;
               post_counter = post_counter + 20'd1;
               if (post_counter == 20'd0 || post_counter >= cfg.post_count_limit) begin
                  post_active  = 1'b0;
                  post_counter = '0;
               end
            end else begin
               ring_insert(rec);
               if (w.store && w.batch_last) begin
                  // The newest entry is the current sample, so the oldest one is
                  // ring_fill - 1 sample periods older.
                  for (k = 0; k < ring_fill; k++) begin
                     add_result(ring[(ring_head + k) % PreDepth],
                                now - 48'(ring_fill - 1 - k), PhaseDump);
                     dump_words++;
                  end
                  ring_head    = (ring_head + ring_fill) % PreDepth;
                  ring_fill    = 0;
                  post_counter = '0;
                  post_active  = (cfg.post_count_limit != 20'd0);
               end
            end
         end
         if (expected_q.size() > before_n) begin
            r      = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
         end
      endfunction

      function void compare_field(input string name, input logic [47:0] expected_v,
                                  input logic [47:0] actual_v);
         if (actual_v !== expected_v) begin
            errors++;
            // Beyond the report limit mismatches are only counted.
            if (errors <= ReportLimit)
               $error("%s mismatch: expected %0h, actual %0h", name, expected_v, actual_v);
         end
      endfunction

      function void check_result(input rsp_data_type got);
         rsp_data_type exp_w;
         words_out++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= ReportLimit)
               $error("result word with nothing expected: out_record %0h stamp %0h",
                      got.out_record, got.stamp);
            return;
         end
         exp_w = expected_q.pop_front();
         compare_field("out_record", 48'(exp_w.out_record), 48'(got.out_record));
         compare_field("stamp", exp_w.stamp, got.stamp);
         compare_field("phase", 48'(exp_w.phase), 48'(got.phase));
         compare_field("last", 48'(exp_w.last), 48'(got.last));
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
// Top-level testbench for pre_post_trigger_capture_top: clock, reset, sample and
// register drivers, a stalling result receiver and a stall watchdog.
// Depends on ptc_pkg and on capture_check_pkg for the scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ptc_pkg::*;
   import capture_check_pkg::*;

   localparam int unsigned IdlePct      = 29;
   localparam int unsigned SettleCycles = 32;
   // Far above the longest quiet stretch of a correct run: a register change
   // settle plus a long run of random stalls during a 64-entry dump.
   localparam int unsigned StallLimit   = 2000;
   localparam int unsigned PhaseCount   = 9;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CsrEventMode;
   logic [19:0]  csr_wdata = '0;

   capture_scoreboard sb = new();
   bit                calm = 1'b0;
   int unsigned       quiet_cycles = 0;
   int unsigned       settings_used = 0;

   pre_post_trigger_capture_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result receiver: checks the word taken at this edge, then picks the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      rsp_stall <= !calm && ($urandom_range(99) < IdlePct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
         $display("watchdog: no word moved for %0d cycles", StallLimit);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(input logic [31:0] rec, input logic st, input logic bl);
      req_data_type w;
      w.record     = rec;
      w.store      = st;
      w.batch_last = bl;
      while (!calm && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(w);
   endtask

   // Stops the sample stream and waits until every expected word has arrived
   // and the back end has had time to finish any work that yields no result.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [19:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic configure(input logic em, input logic se, input logic [6:0] pc,
                            input logic [19:0] pl);
      write_csr(CsrEventMode, 20'(em));
      write_csr(CsrStampEnable, 20'(se));
      write_csr(CsrPreCount, 20'(pc));
      write_csr(CsrPostLimit, pl);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // In event mode, mostly well-formed batches that end in a trigger, with some noise words
   // and some batches that close without a store; in direct mode, only random words.
   task automatic random_phase(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      int unsigned cap;
      int unsigned j;
      sent = 0;
      cap  = (sb.cfg.pre_count > PreDepth) ? PreDepth : sb.cfg.pre_count;
      while (sent < count) begin
         if (!sb.cfg.event_mode || $urandom_range(99) < 15) begin
            send_sample($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end else begin
            if ($urandom_range(1) == 1) len = cap + $urandom_range(3);
            else len = $urandom_range(cap + 3, 1);
            if (len == 0) len = 1;
            for (j = 1; j <= len && sent < count; j++) begin
               if (j == len) send_sample($urandom, 1'($urandom_range(99) < 85), 1'b1);
               else send_sample($urandom, 1'($urandom_range(99) < 8), 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      cfg_type     plan[PhaseCount];
      int unsigned plan_words[PhaseCount];
      int unsigned p;
      int unsigned i;

      plan[0] = '{event_mode: 1'b1, stamp_enable: 1'b1, pre_count: 7'd127,
                  post_count_limit: 20'd5};
      plan[1] = '{event_mode: 1'b1, stamp_enable: 1'b0, pre_count: 7'd3,
                  post_count_limit: 20'd1};
      plan[2] = '{event_mode: 1'b1, stamp_enable: 1'b1, pre_count: 7'd64,
                  post_count_limit: 20'd0};
      plan[3] = '{event_mode: 1'b0, stamp_enable: 1'b1, pre_count: 7'd9,
                  post_count_limit: 20'd2};
      plan[4] = '{event_mode: 1'b1, stamp_enable: 1'b1, pre_count: 7'd8,
                  post_count_limit: 20'd4};
      plan[5] = '{event_mode: 1'b1, stamp_enable: 1'b1, pre_count: 7'd0,
                  post_count_limit: 20'd3};
      plan[6] = '{event_mode: 1'b1, stamp_enable: 1'b1, pre_count: 7'd5,
                  post_count_limit: 20'hFFFFF};
      // Lowers both the ring capacity and the post limit under what phase 6 left.
      plan[7] = '{event_mode: 1'b1, stamp_enable: 1'b1, pre_count: 7'd2,
                  post_count_limit: 20'd2};
      plan[8] = '{event_mode: 1'($urandom_range(1)), stamp_enable: 1'($urandom_range(1)),
                  pre_count: 7'($urandom_range(127)),
                  post_count_limit: 20'($urandom_range(12))};
      plan_words = '{90, 30, 90, 30, 40, 25, 30, 30, 30};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Direct mode: both record extremes, a store-free word and batch_last both ways.
      configure(1'b0, 1'b1, 7'd0, 20'd0);
      send_sample(32'h0000_0000, 1'b1, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_sample(32'hA5A5_A5A5, 1'b0, 1'b1);
      send_sample(32'h5A5A_5A5A, 1'b0, 1'b0);
      drain();

      // Ring overflow, a store without batch end, a full dump, then a post phase
      // whose count is restarted by a store.
      configure(1'b1, 1'b1, 7'd4, 20'd3);
      for (i = 0; i < 6; i++) send_sample(32'h100 + i, 1'b0, 1'b0);
      send_sample(32'h200, 1'b1, 1'b0);
      send_sample(32'h201, 1'b1, 1'b1);
      send_sample(32'h300, 1'b0, 1'b0);
      send_sample(32'h301, 1'b1, 1'b0);
      send_sample(32'h302, 1'b0, 1'b1);
      send_sample(32'h303, 1'b0, 1'b0);
      send_sample(32'h304, 1'b0, 1'b0);
      drain();

      // Empty ring: the trigger yields nothing but still opens the post phase.
      configure(1'b1, 1'b0, 7'd0, 20'd2);
      send_sample(32'h400, 1'b1, 1'b1);
      send_sample(32'h401, 1'b0, 1'b0);
      send_sample(32'h402, 1'b0, 1'b0);
      drain();

      // Zero post limit: dumps open no post phase.
      configure(1'b1, 1'b1, 7'd3, 20'd0);
      send_sample(32'h500, 1'b0, 1'b0);
      send_sample(32'h501, 1'b0, 1'b0);
      send_sample(32'h502, 1'b1, 1'b1);
      send_sample(32'h503, 1'b1, 1'b1);
      drain();

      for (p = 0; p < PhaseCount; p++) begin
         configure(plan[p].event_mode, plan[p].stamp_enable, plan[p].pre_count,
                   plan[p].post_count_limit);
         calm = (p == 4);
         random_phase(plan_words[p]);
         calm = 1'b0;
         drain();
      end

      $display("Covered %0d sample words under %0d register settings, direct and event mode.",
               sb.words_in, settings_used);
      $display("Checked %0d result words: %0d from ring dumps, %0d post-trigger; %0d errors.",
               sb.words_out, sb.dump_words, sb.post_words, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ptc_pkg.sv
rtl/core/ptc_front.sv
rtl/core/ptc_queue.sv
rtl/core/ptc_back.sv
rtl/core/pre_post_trigger_capture_top.sv
bench/capture_check_pkg.sv
bench/tb_top.sv
